// ----- src/ptl_pkg.sv -----
// ----------------------------------------------------------------------------
// PDF token lexer package
// Shared types and constants for the lexer front and back parts.
// ----------------------------------------------------------------------------
package ptl_pkg;

  localparam logic [2:0] KIND_DELIM   = 3'd0;
  localparam logic [2:0] KIND_DOPEN   = 3'd1;
  localparam logic [2:0] KIND_DCLOSE  = 3'd2;
  localparam logic [2:0] KIND_LIT     = 3'd3;
  localparam logic [2:0] KIND_HEX     = 3'd4;
  localparam logic [2:0] KIND_NAME    = 3'd5;
  localparam logic [2:0] KIND_NUM     = 3'd6;
  localparam logic [2:0] KIND_KEY     = 3'd7;

  localparam logic [3:0] ERR_OK       = 4'd0;
  localparam logic [3:0] ERR_LARGE    = 4'd1;
  localparam logic [3:0] ERR_OPEN_LIT = 4'd2;
  localparam logic [3:0] ERR_NAME_ESC = 4'd3;
  localparam logic [3:0] ERR_AFTER_LT = 4'd4;
  localparam logic [3:0] ERR_HEX_CHAR = 4'd5;
  localparam logic [3:0] ERR_OPEN_HEX = 4'd6;
  localparam logic [3:0] ERR_AFTER_GT = 4'd7;
  localparam logic [3:0] ERR_NESTING  = 4'd8;

  localparam logic [15:0] MAX_LEN_RESET = 16'd1023;

  // Byte classes worked out by the front part.
  typedef struct packed {
    logic space;
    logic delim;
    logic numch;
    logic digit;
    logic octal;
    logic hexd;
    logic [3:0] hexv;
  } byte_class_t;

  // One classified word passed from front to back.
  typedef struct packed {
    logic [7:0]  data;
    logic        eoi;
    byte_class_t cls;
  } cls_word_t;

  // One result word.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       nul;
    logic [3:0] err;
  } res_word_t;

  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t c;
    c.space = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    c.delim = (b == "<") || (b == ">") || (b == "(") || (b == ")") || (b == "{") ||
              (b == "}") || (b == "[") || (b == "]") || (b == "/") || (b == "%");
    c.digit = (b >= "0") && (b <= "9");
    c.numch = c.digit || (b == "-") || (b == "+") || (b == ".");
    c.octal = (b >= "0") && (b <= "7");
    c.hexd  = 1'b1;
    c.hexv  = 4'd0;
    if (c.digit) begin
      c.hexv = b[3:0];
    end else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
      c.hexv = b[3:0] + 4'd9;
    end else begin
      c.hexd = 1'b0;
    end
    return c;
  endfunction

endpackage

// ----- src/pdf_token_lexer.sv -----
// ----------------------------------------------------------------------------
// PDF token lexer
// Streaming lexer that turns PDF bytes into tagged, decoded token words.
// ----------------------------------------------------------------------------
// One input word is taken each clock while the two-entry input queue has room;
// the state machine consumes one word a cycle when the four-entry result queue,
// after any pop in the same cycle, holds no more than two words, so the steady
// rate is one word per cycle as long as results are popped as fast as they are
// made. Each accepted input word is registered in the input queue, and its results in
// the result queue, whose head drives the output ports.
module pdf_token_lexer import ptl_pkg::*; #(
  parameter int unsigned PAREN_DEPTH_MAX = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_max_token_len,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_input,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_token_kind,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_token_last,
  output logic        out_had_nul,
  output logic [3:0]  out_error_code
);

  logic [15:0] max_len_r;
  logic        q_valid, q_take;
  cls_word_t   q_word;
  res_word_t   res;

  // Length limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) max_len_r <= MAX_LEN_RESET;
    else if (cfg_we) max_len_r <= cfg_max_token_len;
  end

  ptl_front u_front (
    .clk, .rst_n, .push, .full, .in_byte, .in_end_of_input,
    .q_valid, .q_word, .q_take
  );

  ptl_back #(.PAREN_DEPTH_MAX(PAREN_DEPTH_MAX)) u_back (
    .clk, .rst_n, .max_len(max_len_r), .q_valid, .q_word, .q_take,
    .empty, .pop, .res
  );

  assign out_token_kind = res.kind;
  assign out_byte       = res.data;
  assign out_byte_valid = res.valid;
  assign out_token_last = res.last;
  assign out_had_nul    = res.nul;
  assign out_error_code = res.err;

  // An error always ends a token.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_error_code != ERR_OK) |-> out_token_last)
    else $error("error result without token end");

  // An error result carries no byte.
  a_err_nobyte: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_error_code != ERR_OK) |-> !out_byte_valid)
    else $error("error result carries a byte");

  // The nul flag only appears on a literal's closing word.
  a_nul: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_had_nul) |-> (out_token_last && out_token_kind == KIND_LIT))
    else $error("nul flag on wrong result");

endmodule

// ----- src/ptl_front.sv -----
// ----------------------------------------------------------------------------
// PDF token lexer front part
// Accepts input words, classifies each byte and queues it for the back part.
// ----------------------------------------------------------------------------
module ptl_front import ptl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  logic [7:0] in_byte,
  input  logic      in_end_of_input,
  output logic      q_valid,
  output cls_word_t q_word,
  input  logic      q_take
);

  // Two-entry queue between the parts.
  cls_word_t  mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push;

  assign full    = (cnt_r == 2'd2);
  assign do_push = push && !full;
  assign q_valid = (cnt_r != 2'd0);
  assign q_word  = mem_r[rp_r];

  // Storage of classified words.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= '{data: in_byte, eoi: in_end_of_input, cls: classify(in_byte)};
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (q_take)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, q_take};
    end
  end

endmodule

// ----- src/ptl_back.sv -----
// ----------------------------------------------------------------------------
// PDF token lexer back part
// Runs the lexer state machine on one classified word a cycle while the result
// queue has room, and queues up to two result words per input word.
// ----------------------------------------------------------------------------
module ptl_back import ptl_pkg::*; #(
  parameter int unsigned PAREN_DEPTH_MAX = 255,
  localparam int DW = (PAREN_DEPTH_MAX < 2) ? 1 : $clog2(PAREN_DEPTH_MAX + 1)
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] max_len,
  input  logic        q_valid,
  input  cls_word_t   q_word,
  output logic        q_take,
  output logic        empty,
  input  logic        pop,
  output res_word_t   res
);

  typedef enum logic [3:0] {
    M_IDLE, M_COMMENT, M_LIT, M_ESC, M_OCT, M_NAME, M_NAMEHEX,
    M_NUM, M_KEY, M_LT, M_GT, M_HEX
  } mode_t;

  localparam logic [DW-1:0] DEPTH_MAX = DW'(PAREN_DEPTH_MAX);

  mode_t       mode_r, mode_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  esc_r, esc_nxt;
  logic [1:0]  digs_r, digs_nxt;
  logic        nul_r, nul_nxt;

  // Result queue of four words.
  res_word_t  oq_r [4];
  logic [1:0] owp_r, orp_r;
  logic [2:0] ocnt_r;
  res_word_t  r0, r1;
  logic [1:0] nres;
  logic       do_pop;

  assign do_pop = pop && !empty;
  assign empty  = (ocnt_r == 3'd0);
  assign res    = oq_r[orp_r];
  // Room for two results is needed before a word is taken.
  assign q_take = q_valid && ((ocnt_r - {2'b0, do_pop}) <= 3'd2);

  // Next-state and result logic for one word, including a re-read byte.
  always_comb begin
    logic [7:0]  b;
    byte_class_t c;
    logic        again;
    logic [1:0]  pass;
    mode_t       m;
    logic [7:0]  v;
    logic        sk;
    res_word_t   w;
    b = q_word.data;
    c = q_word.cls;
    mode_nxt = mode_r; depth_nxt = depth_r; len_nxt = len_r;
    esc_nxt = esc_r; digs_nxt = digs_r; nul_nxt = nul_r;
    r0 = '0; r1 = '0; nres = 2'd0;
    again = 1'b0;
    if (q_word.eoi) begin
      w = '{kind: KIND_DELIM, data: 8'd0, valid: 1'b0, last: 1'b1, nul: 1'b0, err: ERR_OK};
      sk = 1'b1;
      unique case (mode_r)
        M_NAME:    w.kind = KIND_NAME;
        M_NUM:     w.kind = KIND_NUM;
        M_KEY:     w.kind = KIND_KEY;
        M_LIT, M_ESC, M_OCT: begin
          w.kind = KIND_LIT; w.err = ERR_OPEN_LIT; w.nul = nul_r;
        end
        M_NAMEHEX: begin w.kind = KIND_NAME;   w.err = ERR_NAME_ESC; end
        M_LT:      begin w.kind = KIND_HEX;    w.err = ERR_AFTER_LT; end
        M_HEX:     begin w.kind = KIND_HEX;    w.err = ERR_OPEN_HEX; end
        M_GT:      begin w.kind = KIND_DCLOSE; w.err = ERR_AFTER_GT; end
        default:   sk = 1'b0;
      endcase
      if (sk) begin r0 = w; nres = 2'd1; end
      mode_nxt = M_IDLE; depth_nxt = '0; len_nxt = '0;
      esc_nxt = '0; digs_nxt = '0; nul_nxt = 1'b0;
    end else begin
      for (pass = 2'd0; pass < 2'd2; pass++) begin
        if (pass == 2'd0 || again) begin
          again = 1'b0;
          m = mode_nxt;
          w = '{kind: KIND_DELIM, data: b, valid: 1'b1, last: 1'b0, nul: 1'b0, err: ERR_OK};
          // sk: a stored byte subject to the length limit
          sk = 1'b0;
          v = b;
          unique case (m)
            M_IDLE: begin
              if (!c.space) begin
                if (b == "%") mode_nxt = M_COMMENT;
                else if (b == "<" || b == ">") begin
                  depth_nxt = '0; len_nxt = '0; esc_nxt = '0; digs_nxt = '0;
                  nul_nxt = 1'b0;
                  mode_nxt = (b == "<") ? M_LT : M_GT;
                end else if (c.delim && b != "(" && b != "/") begin
                  w.last = 1'b1;
                  if (nres == 2'd0) r0 = w; else r1 = w;
                  nres = nres + 2'd1;
                end else begin
                  depth_nxt = '0; len_nxt = 16'd1; esc_nxt = '0; digs_nxt = '0;
                  nul_nxt = 1'b0;
                  if (b == "(") begin w.kind = KIND_LIT; mode_nxt = M_LIT; end
                  else if (b == "/") begin w.kind = KIND_NAME; mode_nxt = M_NAME; end
                  else if (c.numch) begin w.kind = KIND_NUM; mode_nxt = M_NUM; end
                  else begin w.kind = KIND_KEY; mode_nxt = M_KEY; end
                  if (nres == 2'd0) r0 = w; else r1 = w;
                  nres = nres + 2'd1;
                end
              end
            end
            M_COMMENT: if (b == 8'h0A || b == 8'h0D) mode_nxt = M_IDLE;
            M_LIT: begin
              // A re-read byte after a short octal escape may follow a stored byte.
              w.kind = KIND_LIT;
              if (b == "\\") mode_nxt = M_ESC;
              else if (b == "(") begin
                if (depth_nxt >= DEPTH_MAX) begin
                  w = '{kind: KIND_LIT, data: 8'd0, valid: 1'b0, last: 1'b1,
                        nul: nul_nxt, err: ERR_NESTING};
                  if (nres == 2'd0) r0 = w; else r1 = w;
                  nres = nres + 2'd1; mode_nxt = M_IDLE;
                  depth_nxt = '0; len_nxt = '0; esc_nxt = '0; digs_nxt = '0;
                  nul_nxt = 1'b0;
                end else begin depth_nxt = depth_nxt + 1'b1; sk = 1'b1; end
              end else if (b == ")") begin
                if (depth_nxt == '0) begin
                  w = '{kind: KIND_LIT, data: 8'd0, valid: 1'b0, last: 1'b1,
                        nul: nul_nxt, err: ERR_OK};
                  if (nres == 2'd0) r0 = w; else r1 = w;
                  nres = nres + 2'd1; mode_nxt = M_IDLE;
                  len_nxt = '0; esc_nxt = '0; digs_nxt = '0; nul_nxt = 1'b0;
                end else begin depth_nxt = depth_nxt - 1'b1; sk = 1'b1; end
              end else sk = 1'b1;
            end
            M_ESC: begin
              w.kind = KIND_LIT;
              if (c.octal) begin
                esc_nxt = {5'd0, b[2:0]}; digs_nxt = 2'd1; mode_nxt = M_OCT;
              end else begin
                case (b)
                  "n": v = 8'h0A;
                  "r": v = 8'h0D;
                  "t": v = 8'h09;
                  "b": v = 8'h08;
                  "f": v = 8'h0C;
                  default: v = b;
                endcase
                mode_nxt = M_LIT; sk = 1'b1;
              end
            end
            M_OCT: begin
              w.kind = KIND_LIT;
              if (c.octal) begin
                esc_nxt = {esc_nxt[4:0], b[2:0]};
                if (digs_nxt == 2'd2) begin
                  digs_nxt = 2'd0; mode_nxt = M_LIT; v = {esc_r[4:0], b[2:0]}; sk = 1'b1;
                end else digs_nxt = digs_nxt + 2'd1;
              end else begin
                digs_nxt = 2'd0; mode_nxt = M_LIT; v = esc_nxt; sk = 1'b1; again = 1'b1;
              end
            end
            M_NAME: begin
              w.kind = KIND_NAME;
              if (c.space || c.delim) begin
                w = '{kind: KIND_NAME, data: 8'd0, valid: 1'b0, last: 1'b1,
                      nul: 1'b0, err: ERR_OK};
                r0 = w; nres = 2'd1; mode_nxt = M_IDLE;
                len_nxt = '0; esc_nxt = '0; digs_nxt = '0; nul_nxt = 1'b0;
                again = c.delim;
              end else if (b == "#") begin
                esc_nxt = '0; digs_nxt = 2'd0; mode_nxt = M_NAMEHEX;
              end else sk = 1'b1;
            end
            M_NAMEHEX: begin
              w.kind = KIND_NAME;
              if (!c.hexd) begin
                w = '{kind: KIND_NAME, data: 8'd0, valid: 1'b0, last: 1'b1,
                      nul: 1'b0, err: ERR_NAME_ESC};
                r0 = w; nres = 2'd1; mode_nxt = M_IDLE;
                len_nxt = '0; esc_nxt = '0; digs_nxt = '0; nul_nxt = 1'b0;
              end else begin
                esc_nxt = {esc_r[3:0], c.hexv};
                if (digs_r == 2'd1) begin
                  digs_nxt = 2'd0; mode_nxt = M_NAME; v = esc_nxt; sk = 1'b1;
                end else digs_nxt = 2'd1;
              end
            end
            M_NUM, M_KEY: begin
              w.kind = (m == M_NUM) ? KIND_NUM : KIND_KEY;
              if (c.space || ((m == M_NUM) ? !(c.digit || b == ".") : c.delim)) begin
                w.data = 8'd0; w.valid = 1'b0; w.last = 1'b1;
                r0 = w; nres = 2'd1; mode_nxt = M_IDLE;
                len_nxt = '0; esc_nxt = '0; digs_nxt = '0; nul_nxt = 1'b0;
                again = !c.space;
              end else sk = 1'b1;
            end
            M_LT: begin
              if (b == "<") begin
                w = '{kind: KIND_DOPEN, data: "<", valid: 1'b1, last: 1'b0,
                      nul: 1'b0, err: ERR_OK};
                r0 = w; w.last = 1'b1; r1 = w; nres = 2'd2; mode_nxt = M_IDLE;
              end else if (b == ">") begin
                r0 = '{kind: KIND_HEX, data: "<", valid: 1'b1, last: 1'b0,
                       nul: 1'b0, err: ERR_OK};
                r1 = '{kind: KIND_HEX, data: 8'd0, valid: 1'b0, last: 1'b1,
                       nul: 1'b0, err: ERR_OK};
                nres = 2'd2; mode_nxt = M_IDLE;
              end else if (c.hexd || c.space) begin
                r0 = '{kind: KIND_HEX, data: "<", valid: 1'b1, last: 1'b0,
                       nul: 1'b0, err: ERR_OK};
                nres = 2'd1; len_nxt = 16'd1; mode_nxt = M_HEX;
                w.kind = KIND_HEX; sk = !c.space;
              end else begin
                r0 = '{kind: KIND_HEX, data: 8'd0, valid: 1'b0, last: 1'b1,
                       nul: 1'b0, err: ERR_AFTER_LT};
                nres = 2'd1; mode_nxt = M_IDLE;
              end
            end
            M_HEX: begin
              w.kind = KIND_HEX;
              if (b == ">" || (!c.hexd && !c.space)) begin
                r0 = '{kind: KIND_HEX, data: 8'd0, valid: 1'b0, last: 1'b1,
                       nul: 1'b0, err: (b == ">") ? ERR_OK : ERR_HEX_CHAR};
                nres = 2'd1; mode_nxt = M_IDLE; len_nxt = '0;
              end else if (c.hexd) sk = 1'b1;
            end
            M_GT: begin
              if (b == ">") begin
                w = '{kind: KIND_DCLOSE, data: ">", valid: 1'b1, last: 1'b0,
                      nul: 1'b0, err: ERR_OK};
                r0 = w; w.last = 1'b1; r1 = w; nres = 2'd2;
              end else begin
                r0 = '{kind: KIND_DCLOSE, data: 8'd0, valid: 1'b0, last: 1'b1,
                       nul: 1'b0, err: ERR_AFTER_GT};
                nres = 2'd1;
              end
              mode_nxt = M_IDLE;
            end
            default: begin
              mode_nxt = M_IDLE; depth_nxt = '0; len_nxt = '0;
              esc_nxt = '0; digs_nxt = '0; nul_nxt = 1'b0;
            end
          endcase
          // Store one token byte, or end the token when it is too long.
          if (sk) begin
            if (len_nxt < max_len) begin
              if (w.kind == KIND_LIT && v == 8'd0) nul_nxt = 1'b1;
              w.data = v;
              len_nxt = len_nxt + 16'd1;
            end else begin
              w = '{kind: w.kind, data: 8'd0, valid: 1'b0, last: 1'b1,
                    nul: (w.kind == KIND_LIT) ? nul_nxt : 1'b0, err: ERR_LARGE};
              mode_nxt = M_IDLE; depth_nxt = '0; len_nxt = '0;
              esc_nxt = '0; digs_nxt = '0; nul_nxt = 1'b0;
            end
            if (nres == 2'd0) r0 = w; else r1 = w;
            nres = nres + 2'd1;
          end
        end
      end
    end
  end

  // Lexer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; depth_r <= '0; len_r <= '0;
      esc_r <= '0; digs_r <= '0; nul_r <= 1'b0;
    end else if (q_take) begin
      mode_r <= mode_nxt; depth_r <= depth_nxt; len_r <= len_nxt;
      esc_r <= esc_nxt; digs_r <= digs_nxt; nul_r <= nul_nxt;
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (q_take && nres != 2'd0) oq_r[owp_r] <= r0;
    if (q_take && nres == 2'd2) oq_r[owp_r + 2'd1] <= r1;
  end

  // Result queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r <= '0; orp_r <= '0; ocnt_r <= '0;
    end else begin
      if (q_take) owp_r <= owp_r + nres;
      if (do_pop) orp_r <= orp_r + 2'd1;
      ocnt_r <= ocnt_r + (q_take ? {1'b0, nres} : 3'd0) - {2'b0, do_pop};
    end
  end

endmodule

// ----- tb/pdf_token_lexer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PDF token lexer testbench
// Drives byte streams through the lexer with random idling on both sides and
// compares every result word against a behavioural lexer kept in step here.
// ----------------------------------------------------------------------------
module pdf_token_lexer_tb;
  import ptl_pkg::*;

  localparam int DEPTH_MAX    = 255;
  localparam int IDLE_LIMIT   = 20000;
  localparam int RANDOM_ITEMS = 1500;

  typedef enum logic [3:0] {
    LX_IDLE, LX_COMMENT, LX_LIT, LX_ESC, LX_OCT, LX_NAME, LX_NAMEHEX,
    LX_NUM, LX_KEY, LX_LT, LX_GT, LX_HEX
  } lex_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
    logic       chk;
    res_word_t  want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_max_token_len;
  logic        push;
  logic        full;
  logic [7:0]  in_byte;
  logic        in_end_of_input;
  logic        empty;
  logic        pop;
  logic [2:0]  out_token_kind;
  logic [7:0]  out_byte;
  logic        out_byte_valid;
  logic        out_token_last;
  logic        out_had_nul;
  logic [3:0]  out_error_code;

  // Predictor state.
  lex_mode_e   mode;
  int unsigned depth;
  int unsigned tok_len;
  logic [7:0]  esc_val;
  int unsigned esc_cnt;
  logic        nul_flag;
  logic [15:0] len_limit;

  res_word_t   pending_words[$];
  res_word_t   typed_words[$];
  stim_row_t   directed[$];
  int          errors;
  int          words_seen;
  int          bytes_sent;
  int          idle_cycles;

  pdf_token_lexer #(.PAREN_DEPTH_MAX(DEPTH_MAX)) u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_max_token_len(cfg_max_token_len),
    .push(push), .full(full), .in_byte(in_byte), .in_end_of_input(in_end_of_input),
    .empty(empty), .pop(pop), .out_token_kind(out_token_kind), .out_byte(out_byte),
    .out_byte_valid(out_byte_valid), .out_token_last(out_token_last),
    .out_had_nul(out_had_nul), .out_error_code(out_error_code)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic is_ws(logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_delim(logic [7:0] b);
    return b == "<" || b == ">" || b == "(" || b == ")" || b == "{" || b == "}" ||
           b == "[" || b == "]" || b == "/" || b == "%";
  endfunction

  function automatic int hex_digit(logic [7:0] b);
    if (b >= "0" && b <= "9") return b - "0";
    if (b >= "a" && b <= "f") return b - "a" + 10;
    if (b >= "A" && b <= "F") return b - "A" + 10;
    return -1;
  endfunction

  function automatic res_word_t mk(logic [2:0] k, logic [7:0] d, logic v, logic l,
                                   logic n, logic [3:0] e);
    res_word_t w;
    w.kind = k; w.data = d; w.valid = v; w.last = l; w.nul = n; w.err = e;
    return w;
  endfunction

  task automatic clear_token();
    mode = LX_IDLE; depth = 0; tok_len = 0; esc_val = '0; esc_cnt = 0; nul_flag = 1'b0;
  endtask

  task automatic close_token(logic [2:0] k, logic [3:0] e);
    pending_words.push_back(mk(k, 8'h00, 1'b0, 1'b1, k == KIND_LIT ? nul_flag : 1'b0, e));
    clear_token();
  endtask

  task automatic open_token(logic [2:0] k, logic [7:0] b, lex_mode_e m);
    clear_token();
    tok_len = 1;
    pending_words.push_back(mk(k, b, 1'b1, 1'b0, 1'b0, ERR_OK));
    mode = m;
  endtask

  task automatic append_byte(logic [2:0] k, logic [7:0] b);
    if (tok_len < len_limit) begin
      if (k == KIND_LIT && b == 8'h00) nul_flag = 1'b1;
      pending_words.push_back(mk(k, b, 1'b1, 1'b0, 1'b0, ERR_OK));
      tok_len++;
    end else begin
      close_token(k, ERR_LARGE);
    end
  endtask

  // One lexer step on a byte; sets reread when the byte must be seen again.
  task automatic lex_byte(logic [7:0] b, output logic reread);
    logic [7:0] v;
    reread = 1'b0;
    case (mode)
      LX_IDLE: begin
        if (!is_ws(b)) begin
          if (b == "%") mode = LX_COMMENT;
          else if (b == "<") begin clear_token(); mode = LX_LT; end
          else if (b == ">") begin clear_token(); mode = LX_GT; end
          else if (b == "(") open_token(KIND_LIT, b, LX_LIT);
          else if (b == "/") open_token(KIND_NAME, b, LX_NAME);
          else if (is_delim(b))
            pending_words.push_back(mk(KIND_DELIM, b, 1'b1, 1'b1, 1'b0, ERR_OK));
          else if ((b >= "0" && b <= "9") || b == "-" || b == "+" || b == ".")
            open_token(KIND_NUM, b, LX_NUM);
          else open_token(KIND_KEY, b, LX_KEY);
        end
      end
      LX_COMMENT: if (b == 8'h0A || b == 8'h0D) mode = LX_IDLE;
      LX_LIT: begin
        if (b == "\\") mode = LX_ESC;
        else if (b == "(") begin
          if (depth >= DEPTH_MAX) close_token(KIND_LIT, ERR_NESTING);
          else begin depth++; append_byte(KIND_LIT, b); end
        end else if (b == ")") begin
          if (depth == 0) close_token(KIND_LIT, ERR_OK);
          else begin depth--; append_byte(KIND_LIT, b); end
        end else append_byte(KIND_LIT, b);
      end
      LX_ESC: begin
        if (b >= "0" && b <= "7") begin
          esc_val = b - "0"; esc_cnt = 1; mode = LX_OCT;
        end else begin
          v = b;
          if (b == "n") v = 8'h0A;
          else if (b == "r") v = 8'h0D;
          else if (b == "t") v = 8'h09;
          else if (b == "b") v = 8'h08;
          else if (b == "f") v = 8'h0C;
          mode = LX_LIT;
          append_byte(KIND_LIT, v);
        end
      end
      LX_OCT: begin
        if (b >= "0" && b <= "7") begin
          esc_val = {esc_val[4:0], 3'(b - "0")};
          esc_cnt++;
          if (esc_cnt >= 3) begin
            esc_cnt = 0; mode = LX_LIT; append_byte(KIND_LIT, esc_val);
          end
        end else begin
          esc_cnt = 0; mode = LX_LIT; append_byte(KIND_LIT, esc_val);
          reread = 1'b1;
        end
      end
      LX_NAME: begin
        if (is_ws(b)) close_token(KIND_NAME, ERR_OK);
        else if (is_delim(b)) begin close_token(KIND_NAME, ERR_OK); reread = 1'b1; end
        else if (b == "#") begin esc_val = '0; esc_cnt = 0; mode = LX_NAMEHEX; end
        else append_byte(KIND_NAME, b);
      end
      LX_NAMEHEX: begin
        if (hex_digit(b) < 0) close_token(KIND_NAME, ERR_NAME_ESC);
        else begin
          esc_val = {esc_val[3:0], 4'(hex_digit(b))};
          esc_cnt++;
          if (esc_cnt >= 2) begin
            esc_cnt = 0; mode = LX_NAME; append_byte(KIND_NAME, esc_val);
          end
        end
      end
      LX_NUM: begin
        if (is_ws(b)) close_token(KIND_NUM, ERR_OK);
        else if (!(b >= "0" && b <= "9") && b != ".") begin
          close_token(KIND_NUM, ERR_OK); reread = 1'b1;
        end else append_byte(KIND_NUM, b);
      end
      LX_KEY: begin
        if (is_ws(b)) close_token(KIND_KEY, ERR_OK);
        else if (is_delim(b)) begin close_token(KIND_KEY, ERR_OK); reread = 1'b1; end
        else append_byte(KIND_KEY, b);
      end
      LX_LT: begin
        if (b == "<") begin
          pending_words.push_back(mk(KIND_DOPEN, "<", 1'b1, 1'b0, 1'b0, ERR_OK));
          pending_words.push_back(mk(KIND_DOPEN, "<", 1'b1, 1'b1, 1'b0, ERR_OK));
          clear_token();
        end else if (b == ">") begin
          pending_words.push_back(mk(KIND_HEX, "<", 1'b1, 1'b0, 1'b0, ERR_OK));
          close_token(KIND_HEX, ERR_OK);
        end else if (hex_digit(b) >= 0 || is_ws(b)) begin
          tok_len = 1;
          pending_words.push_back(mk(KIND_HEX, "<", 1'b1, 1'b0, 1'b0, ERR_OK));
          mode = LX_HEX;
          if (!is_ws(b)) append_byte(KIND_HEX, b);
        end else close_token(KIND_HEX, ERR_AFTER_LT);
      end
      LX_HEX: begin
        if (b == ">") close_token(KIND_HEX, ERR_OK);
        else if (hex_digit(b) >= 0) append_byte(KIND_HEX, b);
        else if (!is_ws(b)) close_token(KIND_HEX, ERR_HEX_CHAR);
      end
      LX_GT: begin
        if (b == ">") begin
          pending_words.push_back(mk(KIND_DCLOSE, ">", 1'b1, 1'b0, 1'b0, ERR_OK));
          pending_words.push_back(mk(KIND_DCLOSE, ">", 1'b1, 1'b1, 1'b0, ERR_OK));
          clear_token();
        end else close_token(KIND_DCLOSE, ERR_AFTER_GT);
      end
      default: clear_token();
    endcase
  endtask

  // Works out the result words of one accepted input word.
  task automatic predict_word(logic [7:0] b, logic eoi);
    logic again;
    if (eoi) begin
      case (mode)
        LX_NAME:                  close_token(KIND_NAME, ERR_OK);
        LX_NUM:                   close_token(KIND_NUM, ERR_OK);
        LX_KEY:                   close_token(KIND_KEY, ERR_OK);
        LX_LIT, LX_ESC, LX_OCT:   close_token(KIND_LIT, ERR_OPEN_LIT);
        LX_NAMEHEX:               close_token(KIND_NAME, ERR_NAME_ESC);
        LX_LT:                    close_token(KIND_HEX, ERR_AFTER_LT);
        LX_HEX:                   close_token(KIND_HEX, ERR_OPEN_HEX);
        LX_GT:                    close_token(KIND_DCLOSE, ERR_AFTER_GT);
        default:                  clear_token();
      endcase
    end else begin
      lex_byte(b, again);
      if (again) lex_byte(b, again);
    end
  endtask

  // Random gap: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Sends one word and waits until it is accepted; push stays high for a
  // following word sent with no gap.
  task automatic send_word(logic [7:0] b, logic eoi);
    int gap;
    gap = gap_len();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_byte <= b;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_word(b, eoi);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  // Waits for all words to drain, plus the pipeline latency, then writes the limit.
  task automatic set_limit(logic [15:0] lim);
    send_word(8'h00, 1'b1);
    push <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_max_token_len <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    len_limit = lim;
  endtask

  // Random byte biased toward the lexer's interesting characters.
  function automatic logic [7:0] pick_byte();
    string pool;
    pool = "<>()[]{}/%#\\ \n0123456789-+.abcfnrtAF";
    if ($urandom_range(3) == 0) return 8'($urandom_range(255));
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  // Well-formed token with random content, sometimes broken at the end.
  task automatic send_token();
    int n;
    n = $urandom_range(6, 1);
    case ($urandom_range(7))
      0: begin
        send_word("(", 1'b0);
        repeat (n) begin
          case ($urandom_range(4))
            0: begin send_word("\\", 1'b0); send_word(pick_byte(), 1'b0); end
            1: begin
              send_word("\\", 1'b0);
              repeat ($urandom_range(3, 1)) send_word(8'("0" + $urandom_range(7)), 1'b0);
            end
            2: begin send_word("(", 1'b0); send_word(pick_byte(), 1'b0); send_word(")", 1'b0); end
            default: send_word(8'($urandom_range(255)), 1'b0);
          endcase
        end
        send_word(")", 1'b0);
      end
      1: begin
        send_word("/", 1'b0);
        repeat (n) begin
          if ($urandom_range(3) == 0) begin
            send_word("#", 1'b0);
            send_word(pick_byte(), 1'b0);
            send_word(pick_byte(), 1'b0);
          end else send_word(8'("a" + $urandom_range(25)), 1'b0);
        end
      end
      2: begin
        send_word("<", 1'b0);
        repeat (n)
          send_word($urandom_range(5) == 0 ? 8'h20 : 8'("0" + $urandom_range(9)), 1'b0);
        send_word(">", 1'b0);
      end
      3: repeat (n) send_word(8'("0" + $urandom_range(9)), 1'b0);
      4: send_text($urandom_range(1) ? "<<" : ">>");
      5: repeat (n) send_word(8'("a" + $urandom_range(25)), 1'b0);
      default: repeat (n) send_word(pick_byte(), 1'b0);
    endcase
    if ($urandom_range(2) == 0) send_word(pick_byte(), 1'b0);
    else send_word(" ", 1'b0);
    if ($urandom_range(30) == 0) send_word(8'h00, 1'b1);
  endtask

  // Result side: random pop pressure and the comparison.
  initial begin
    res_word_t got;
    res_word_t want;
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (pop && !empty && rst_n) begin
        got = '{out_token_kind, out_byte, out_byte_valid, out_token_last, out_had_nul,
                out_error_code};
        words_seen++;
        if (pending_words.size() == 0) begin
          $display("%0t: unexpected word %p", $time, got);
          errors++;
        end else begin
          want = pending_words.pop_front();
          if (typed_words.size() != 0 && typed_words[0] == want) void'(typed_words.pop_front());
          if (got.kind != want.kind || got.data != want.data || got.valid != want.valid ||
              got.last != want.last || got.nul != want.nul || got.err != want.err) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            errors++;
          end
        end
      end
      pop <= ($urandom_range(9) < 7) || ($urandom_range(3) == 0 && $time > 0);
    end
  end

  // Watchdog on cycles in which nothing moves.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    stim_row_t row;
    errors = 0; words_seen = 0; bytes_sent = 0;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_max_token_len = MAX_LEN_RESET;
    push = 1'b0; in_byte = '0; in_end_of_input = 1'b0;
    len_limit = MAX_LEN_RESET;
    clear_token();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: typed words for the obvious cases, predictor for the rest.
    directed.push_back('{"[", 1'b0, 1'b1, mk(KIND_DELIM, "[", 1'b1, 1'b1, 1'b0, ERR_OK)});
    directed.push_back('{"}", 1'b0, 1'b1, mk(KIND_DELIM, "}", 1'b1, 1'b1, 1'b0, ERR_OK)});
    directed.push_back('{"<", 1'b0, 1'b0, '0});
    directed.push_back('{"x", 1'b0, 1'b1, mk(KIND_HEX, 8'h00, 1'b0, 1'b1, 1'b0, ERR_AFTER_LT)});
    directed.push_back('{">", 1'b0, 1'b0, '0});
    directed.push_back('{"a", 1'b0, 1'b1, mk(KIND_DCLOSE, 8'h00, 1'b0, 1'b1, 1'b0, ERR_AFTER_GT)});
    directed.push_back('{"/", 1'b0, 1'b0, '0});
    directed.push_back('{"#", 1'b0, 1'b0, '0});
    directed.push_back('{"g", 1'b0, 1'b1, mk(KIND_NAME, 8'h00, 1'b0, 1'b1, 1'b0, ERR_NAME_ESC)});
    directed.push_back('{"<", 1'b0, 1'b0, '0});
    directed.push_back('{"a", 1'b0, 1'b0, '0});
    directed.push_back('{"z", 1'b0, 1'b1, mk(KIND_HEX, 8'h00, 1'b0, 1'b1, 1'b0, ERR_HEX_CHAR)});
    directed.push_back('{"(", 1'b0, 1'b0, '0});
    directed.push_back('{8'hFF, 1'b0, 1'b0, '0});
    directed.push_back('{8'h00, 1'b1, 1'b1, mk(KIND_LIT, 8'h00, 1'b0, 1'b1, 1'b0, ERR_OPEN_LIT)});
    directed.push_back('{"<", 1'b0, 1'b0, '0});
    directed.push_back('{"F", 1'b0, 1'b0, '0});
    directed.push_back('{8'h00, 1'b1, 1'b1, mk(KIND_HEX, 8'h00, 1'b0, 1'b1, 1'b0, ERR_OPEN_HEX)});
    foreach (directed[i]) begin
      row = directed[i];
      if (row.chk) typed_words.push_back(row.want);
      send_word(row.data, row.eoi);
    end
    // Escapes, nesting, names, numbers and re-read delimiters via the predictor.
    send_text("(a\\n\\(\\000\\12x\\7)(b)c) %c\n<< >> <> /N#41x/y 12.5-3 obj[ 4");
    send_word(8'h00, 1'b1);

    // Nesting past the depth limit.
    send_word("(", 1'b0);
    repeat (DEPTH_MAX + 1) send_word("(", 1'b0);
    send_word(8'h00, 1'b1);

    // Random part across several length limits, extremes included.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_limit(16'd1);
        1: set_limit(16'd3);
        2: set_limit(16'hFFFF);
        3: set_limit(16'($urandom_range(12, 2)));
        default: set_limit(MAX_LEN_RESET);
      endcase
      repeat (RANDOM_ITEMS / 50) send_token();
      // Noise.
      repeat (RANDOM_ITEMS / 50) send_word(8'($urandom_range(255)), $urandom_range(40) == 0);
    end
    send_word(8'h00, 1'b1);
    push <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (typed_words.size() != 0) begin
      $display("%0t: %0d typed words never matched", $time, typed_words.size());
      errors++;
    end
    $display("Sent %0d input words over five length limits; checked %0d result words.",
             bytes_sent, words_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- pdf_token_lexer.f -----
src/ptl_pkg.sv
src/ptl_front.sv
src/ptl_back.sv
src/pdf_token_lexer.sv
tb/pdf_token_lexer_tb.sv
